FILE: src/btgs_pkg.sv
// Shared constants, types and helper functions for the biterm topic Gibbs sampler.
package btgs_pkg;

	localparam int MAX_VOCAB  = 1024;
	localparam int MAX_TOPICS = 64;
	localparam int COUNT_BITS = 24;

	localparam int WORD_W  = $clog2(MAX_VOCAB);
	localparam int TOPIC_W = $clog2(MAX_TOPICS);
	localparam int TU_W    = TOPIC_W + 1;
	localparam int WTC_AW  = WORD_W + TOPIC_W;

	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [63:0] ALL_ONES = {64{1'b1}};

	localparam logic [31:0] ALPHA_RST = 32'd65536;
	localparam logic [31:0] BETA_RST  = 32'd655;
	localparam logic [10:0] VOCAB_RST = 11'd1024;
	localparam logic [6:0]  TOPIC_RST = 7'd64;

	// configuration register indexes
	localparam logic [1:0] REG_ALPHA  = 2'd0;
	localparam logic [1:0] REG_BETA   = 2'd1;
	localparam logic [1:0] REG_VOCAB  = 2'd2;
	localparam logic [1:0] REG_TOPICS = 2'd3;

	typedef enum logic [15:0] {
		S_CLR  = 16'h0001,
		S_IDLE = 16'h0002,
		S_URD  = 16'h0004,
		S_UWR  = 16'h0008,
		S_WRD1 = 16'h0010,
		S_WRD2 = 16'h0020,
		S_WCAP = 16'h0040,
		S_MUL  = 16'h0080,
		S_MPST = 16'h0100,
		S_DIV  = 16'h0200,
		S_WACC = 16'h0400,
		S_SRD  = 16'h0800,
		S_SCHK = 16'h1000
	} state_t;

	// destination of a product from the shared multiplier
	typedef enum logic [1:0] {
		M_AB  = 2'd0,
		M_NUM = 2'd1,
		M_DEN = 2'd2,
		M_THR = 2'd3
	} msel_t;

	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? ALL_ONES : s[63:0];
	endfunction

	// Q48.16 product from a 128-bit raw product, saturated
	function automatic logic [63:0] q16_of(input logic [127:0] p);
		return (p[127:80] != 48'd0) ? ALL_ONES : p[79:16];
	endfunction

endpackage

FILE: src/biterm_topic_gibbs_sampler.sv
// Biterm topic model collapsed Gibbs sampler: count tables, weighting and topic draw.
// After reset the block clears the word-topic and topic count tables, busy stays high.
// Mode 0 (load): after the start beat the block runs three read-write pairs, then done strobes.
// Mode 1: decrement, then per topic: table reads, three products on the shared 32x32 multiplier,
// divide if needed, accumulate; then up to tu select steps pick the topic, or a zero total uses rf.
// One item at a time; results are a one-cycle done strobe, the receiver cannot stall.
module biterm_topic_gibbs_sampler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        mode,
	input  logic [9:0]  first_word,
	input  logic [9:0]  second_word,
	input  logic [5:0]  topic,
	input  logic [31:0] random_fraction,
	output logic        done,
	output logic [5:0]  new_topic,
	output logic        count_saturated,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int CB = btgs_pkg::COUNT_BITS;
	localparam int TW = btgs_pkg::TOPIC_W;
	localparam int WW = btgs_pkg::WORD_W;
	localparam int AW = btgs_pkg::WTC_AW;
	localparam int UW = btgs_pkg::TU_W;

	btgs_pkg::state_t state_q;
	btgs_pkg::msel_t  msel_q;

	logic [31:0] alpha_q, beta_q;
	logic [10:0] vocab_q;
	logic [6:0]  topics_q;

	logic [WW-1:0] w1_q, w2_q;
	logic [TW-1:0] utgt_q, chosen_q, t_q;
	logic [31:0]   rf_q;
	logic          uinc_q, sat_q;
	logic [1:0]    uk_q;
	logic [UW-1:0] tu_q;
	logic [42:0]   bv_q;
	logic [AW-1:0] clr_q;

	logic [CB-1:0] nz_q, n1_q;
	logic [63:0]   b2_q, d_q, num_q, den_q, total_q, thr_q, run_q, w_q;
	logic [63:0]   rem_q, quo_q, mul_a_q, mul_b_q;
	logic [31:0]   lo_q;
	logic [5:0]    dcnt_q;
	logic [2:0]    mcnt_q;
	logic [63:0]   pp_q;
	logic [1:0]    sh_q;
	logic [127:0]  acc_q;
	logic          done_q, nsat_q;
	logic [TW-1:0] ntopic_q;

	// memories
	logic [CB-1:0] wtc_mem [2**AW];
	logic [CB-1:0] tc_mem  [2**TW];
	logic [63:0]   wt_mem  [2**TW];
	logic [CB-1:0] wtc_rdata_q, tc_rdata_q;
	logic [63:0]   wt_rdata_q;

	logic [AW-1:0] wtc_raddr, wtc_waddr, uaddr;
	logic [TW-1:0] tc_raddr;
	logic          wtc_we, tc_we, wt_we;
	logic [CB-1:0] wr_cnt, old_cnt, new_cnt;
	logic          upd_sat;

	// effective register values
	logic [UW-1:0] tu_eff;
	logic [10:0]   v_eff;
	always_comb begin
		if (topics_q == 7'd0) tu_eff = UW'(1);
		else if ({25'd0, topics_q} > btgs_pkg::MAX_TOPICS) tu_eff = UW'(btgs_pkg::MAX_TOPICS);
		else tu_eff = UW'(topics_q);
		v_eff = (vocab_q == 11'd0) ? 11'd1 : vocab_q;
	end

	// count update
	always_comb begin
		old_cnt = (uk_q == 2'd2) ? tc_rdata_q : wtc_rdata_q;
		upd_sat = 1'b0;
		new_cnt = old_cnt;
		if (uinc_q) begin
			if (old_cnt == btgs_pkg::CNT_MAX) upd_sat = 1'b1;
			else new_cnt = old_cnt + CB'(1);
		end else begin
			if (old_cnt == '0) upd_sat = 1'b1;
			else new_cnt = old_cnt - CB'(1);
		end
	end

	assign uaddr = {(uk_q == 2'd1) ? w2_q : w1_q, utgt_q};

	always_comb begin
		wtc_raddr = uaddr;
		tc_raddr  = utgt_q;
		case (state_q)
			btgs_pkg::S_WRD1: begin
				wtc_raddr = {w1_q, t_q};
				tc_raddr  = t_q;
			end
			btgs_pkg::S_WRD2: wtc_raddr = {w2_q, t_q};
			default: ;
		endcase
		wtc_we    = (state_q == btgs_pkg::S_CLR) ||
			((state_q == btgs_pkg::S_UWR) && (uk_q != 2'd2));
		tc_we     = (state_q == btgs_pkg::S_CLR) ||
			((state_q == btgs_pkg::S_UWR) && (uk_q == 2'd2));
		wtc_waddr = (state_q == btgs_pkg::S_CLR) ? clr_q : uaddr;
		wr_cnt    = (state_q == btgs_pkg::S_CLR) ? '0 : new_cnt;
		wt_we     = (state_q == btgs_pkg::S_WACC);
	end

	always_ff @(posedge clk) begin
		if (wtc_we) wtc_mem[wtc_waddr] <= wr_cnt;
		wtc_rdata_q <= wtc_mem[wtc_raddr];
	end

	always_ff @(posedge clk) begin
		if (tc_we) tc_mem[(state_q == btgs_pkg::S_CLR) ? clr_q[TW-1:0] : utgt_q] <= wr_cnt;
		tc_rdata_q <= tc_mem[tc_raddr];
	end

	always_ff @(posedge clk) begin
		if (wt_we) wt_mem[t_q] <= w_q;
		wt_rdata_q <= wt_mem[t_q];
	end

	// datapath helpers
	logic [63:0]  a_op, b1_op, b2_op, d_op, q16, tot_nx, run_nx;
	logic [63:0]  rem_sh, rem_nx;
	logic         qbit;
	logic [31:0]  ma_part, mb_part;
	logic [127:0] pp_shift;
	logic [38:0]  rf_tu;
	logic         t_last;

	always_comb begin
		a_op  = ({40'd0, nz_q} << 16) + {32'd0, alpha_q};
		b1_op = ({40'd0, n1_q} << 16) + {32'd0, beta_q};
		b2_op = ({40'd0, wtc_rdata_q} << 16) + {32'd0, beta_q};
		d_op  = ({39'd0, nz_q, 1'b0} << 16) + {21'd0, bv_q};
		q16   = btgs_pkg::q16_of(acc_q);
		tot_nx = btgs_pkg::sat_add(total_q, w_q);
		run_nx = btgs_pkg::sat_add(run_q, wt_rdata_q);
		rem_sh = {rem_q[62:0], lo_q[31]};
		qbit   = rem_q[63] || (rem_sh >= den_q);
		rem_nx = qbit ? rem_sh - den_q : rem_sh;
		ma_part = mcnt_q[1] ? mul_a_q[63:32] : mul_a_q[31:0];
		mb_part = mcnt_q[0] ? mul_b_q[63:32] : mul_b_q[31:0];
		case (sh_q)
			2'd0:    pp_shift = {64'd0, pp_q};
			2'd1:    pp_shift = {32'd0, pp_q, 32'd0};
			default: pp_shift = {pp_q, 64'd0};
		endcase
		rf_tu  = rf_q * {25'd0, tu_q};
		t_last = ({1'b0, t_q} == tu_q - UW'(1));
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= btgs_pkg::S_CLR;
			clr_q    <= '0;
			done_q   <= 1'b0;
			alpha_q  <= btgs_pkg::ALPHA_RST;
			beta_q   <= btgs_pkg::BETA_RST;
			vocab_q  <= btgs_pkg::VOCAB_RST;
			topics_q <= btgs_pkg::TOPIC_RST;
			msel_q   <= btgs_pkg::M_AB;
			uk_q     <= '0;
			mcnt_q   <= '0;
			dcnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid) begin
				case (cfg_index)
					btgs_pkg::REG_ALPHA:  alpha_q  <= cfg_data;
					btgs_pkg::REG_BETA:   beta_q   <= cfg_data;
					btgs_pkg::REG_VOCAB:  vocab_q  <= cfg_data[10:0];
					btgs_pkg::REG_TOPICS: topics_q <= cfg_data[6:0];
					default: ;
				endcase
			end
			case (state_q)
				btgs_pkg::S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (&clr_q) state_q <= btgs_pkg::S_IDLE;
				end
				btgs_pkg::S_IDLE: begin
					if (start) begin
						uk_q    <= '0;
						state_q <= btgs_pkg::S_URD;
					end
				end
				btgs_pkg::S_URD: state_q <= btgs_pkg::S_UWR;
				btgs_pkg::S_UWR: begin
					uk_q <= uk_q + 2'd1;
					if (uk_q != 2'd2) state_q <= btgs_pkg::S_URD;
					else if (uinc_q) begin
						done_q  <= 1'b1;
						state_q <= btgs_pkg::S_IDLE;
					end else state_q <= btgs_pkg::S_WRD1;
				end
				btgs_pkg::S_WRD1: state_q <= btgs_pkg::S_WRD2;
				btgs_pkg::S_WRD2: state_q <= btgs_pkg::S_WCAP;
				btgs_pkg::S_WCAP: begin
					msel_q  <= btgs_pkg::M_AB;
					mcnt_q  <= '0;
					state_q <= btgs_pkg::S_MUL;
				end
				btgs_pkg::S_MUL: begin
					mcnt_q <= mcnt_q + 3'd1;
					if (mcnt_q == 3'd4) state_q <= btgs_pkg::S_MPST;
				end
				btgs_pkg::S_MPST: begin
					mcnt_q <= '0;
					dcnt_q <= '0;
					case (msel_q)
						btgs_pkg::M_AB: begin
							msel_q  <= btgs_pkg::M_NUM;
							state_q <= btgs_pkg::S_MUL;
						end
						btgs_pkg::M_NUM: begin
							msel_q  <= btgs_pkg::M_DEN;
							state_q <= btgs_pkg::S_MUL;
						end
						btgs_pkg::M_DEN: begin
							if (q16 == 64'd0 || num_q[63:32] >= q16) state_q <= btgs_pkg::S_WACC;
							else state_q <= btgs_pkg::S_DIV;
						end
						default: state_q <= btgs_pkg::S_SRD;
					endcase
				end
				btgs_pkg::S_DIV: begin
					dcnt_q <= dcnt_q + 6'd1;
					if (&dcnt_q) state_q <= btgs_pkg::S_WACC;
				end
				btgs_pkg::S_WACC: begin
					if (!t_last) state_q <= btgs_pkg::S_WRD1;
					else if (tot_nx == 64'd0) begin
						uk_q    <= '0;
						state_q <= btgs_pkg::S_URD;
					end else begin
						msel_q  <= btgs_pkg::M_THR;
						mcnt_q  <= '0;
						state_q <= btgs_pkg::S_MUL;
					end
				end
				btgs_pkg::S_SRD: state_q <= btgs_pkg::S_SCHK;
				btgs_pkg::S_SCHK: begin
					if (run_nx > thr_q || t_last) begin
						uk_q    <= '0;
						state_q <= btgs_pkg::S_URD;
					end else state_q <= btgs_pkg::S_SRD;
				end
				default: state_q <= btgs_pkg::S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			btgs_pkg::S_IDLE: begin
				w1_q     <= first_word;
				w2_q     <= second_word;
				utgt_q   <= topic;
				chosen_q <= topic;
				rf_q     <= random_fraction;
				uinc_q   <= ~mode;
				sat_q    <= 1'b0;
				tu_q     <= tu_eff;
				bv_q     <= beta_q * v_eff;
				t_q      <= '0;
				total_q  <= '0;
			end
			btgs_pkg::S_UWR: begin
				sat_q <= sat_q | upd_sat;
				if (uk_q == 2'd2 && uinc_q) begin
					ntopic_q <= chosen_q;
					nsat_q   <= sat_q | upd_sat;
				end
			end
			btgs_pkg::S_WRD2: begin
				nz_q <= tc_rdata_q;
				n1_q <= wtc_rdata_q;
			end
			btgs_pkg::S_WCAP: begin
				b2_q    <= b2_op;
				d_q     <= d_op;
				mul_a_q <= a_op;
				mul_b_q <= b1_op;
			end
			btgs_pkg::S_MUL: begin
				if (mcnt_q == 3'd0) acc_q <= '0;
				else acc_q <= acc_q + pp_shift;
				pp_q <= ma_part * mb_part;
				sh_q <= 2'(mcnt_q[1]) + 2'(mcnt_q[0]);
			end
			btgs_pkg::S_MPST: begin
				case (msel_q)
					btgs_pkg::M_AB: begin
						mul_a_q <= q16;
						mul_b_q <= b2_q;
					end
					btgs_pkg::M_NUM: begin
						num_q   <= q16;
						mul_a_q <= d_q;
						mul_b_q <= d_q;
					end
					btgs_pkg::M_DEN: begin
						den_q <= q16;
						rem_q <= {32'd0, num_q[63:32]};
						lo_q  <= num_q[31:0];
						quo_q <= '0;
						if (q16 == 64'd0) w_q <= '0;
						else w_q <= btgs_pkg::ALL_ONES;
					end
					default: begin
						thr_q <= acc_q[95:32];
						t_q   <= '0;
						run_q <= '0;
					end
				endcase
			end
			btgs_pkg::S_DIV: begin
				rem_q <= rem_nx;
				lo_q  <= {lo_q[30:0], 1'b0};
				quo_q <= {quo_q[62:0], qbit};
				if (&dcnt_q) w_q <= {quo_q[62:0], qbit};
			end
			btgs_pkg::S_WACC: begin
				total_q <= tot_nx;
				if (!t_last) t_q <= t_q + TW'(1);
				else if (tot_nx == 64'd0) begin
					chosen_q <= rf_tu[32 +: TW];
					utgt_q   <= rf_tu[32 +: TW];
					uinc_q   <= 1'b1;
				end else begin
					mul_a_q <= tot_nx;
					mul_b_q <= {32'd0, rf_q};
				end
			end
			btgs_pkg::S_SCHK: begin
				run_q <= run_nx;
				if (run_nx > thr_q || t_last) begin
					chosen_q <= t_q;
					utgt_q   <= t_q;
					uinc_q   <= 1'b1;
				end else t_q <= t_q + TW'(1);
			end
			default: ;
		endcase
	end

	assign busy            = (state_q != btgs_pkg::S_IDLE);
	assign cfg_ready       = 1'b1;
	assign done            = done_q;
	assign new_topic       = ntopic_q;
	assign count_saturated = nsat_q;

endmodule
